/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/segx_pkg.sv */
// ----------------------------------------------------------------------------
// segx_pkg
// Request and result types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segx_pkg;
  localparam int unsigned CoordBits = 16;

  typedef struct packed {
    logic signed [CoordBits-1:0] first_start_x;
    logic signed [CoordBits-1:0] first_start_y;
    logic signed [CoordBits-1:0] first_end_x;
    logic signed [CoordBits-1:0] first_end_y;
    logic signed [CoordBits-1:0] second_start_x;
    logic signed [CoordBits-1:0] second_start_y;
    logic signed [CoordBits-1:0] second_end_x;
    logic signed [CoordBits-1:0] second_end_y;
  } seg_req_t;

  typedef struct packed {
    logic                        hit;
    logic signed [CoordBits-1:0] cross_x;
    logic signed [CoordBits-1:0] cross_y;
  } seg_rsp_t;
endpackage

/* hw/rtl/segx_div.sv */
// ----------------------------------------------------------------------------
// segx_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// The quotient must fit QuotBits bits, i.e. num < den << QuotBits.
// ----------------------------------------------------------------------------
module segx_div #(
  parameter int unsigned NumBits = 51,
  parameter int unsigned DenBits = 35,
  parameter int unsigned QuotBits = 17,
  parameter int unsigned SideBits = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [DenBits-1:0]  den_i,
  input  logic [SideBits-1:0] side_i,
  output logic                valid_o,
  output logic [QuotBits-1:0] quot_o,
  output logic [SideBits-1:0] side_o
);
  // stage k holds remainder, remaining dividend bits shifted in as quotient bits
  logic [QuotBits-1:0] vld_q;
  logic [DenBits:0]    rem_q  [QuotBits];
  logic [QuotBits-1:0] nq_q   [QuotBits];
  logic [DenBits-1:0]  den_q  [QuotBits];
  logic [SideBits-1:0] side_q [QuotBits];

  for (genvar k = 0; k < QuotBits; k++) begin : g_stage
    logic                vld_in;
    logic [DenBits:0]    rem_in;
    logic [QuotBits-1:0] nq_in;
    logic [DenBits-1:0]  den_in;
    logic [SideBits-1:0] side_in;
    logic [DenBits:0]    sh;
    logic [DenBits+1:0]  diff;
    if (k == 0) begin : g_first
      // upper dividend bits start as the remainder, already below den
      assign vld_in  = valid_i;
      assign rem_in  = (DenBits+1)'(num_i[NumBits-1:QuotBits]);
      assign nq_in   = num_i[QuotBits-1:0];
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end
    assign sh   = {rem_in[DenBits-1:0], nq_in[QuotBits-1]};
    assign diff = {1'b0, sh} - {2'b00, den_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= diff[DenBits+1] ? sh : diff[DenBits:0];
        nq_q[k]   <= {nq_in[QuotBits-2:0], ~diff[DenBits+1]};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QuotBits-1];
  assign quot_o  = nq_q[QuotBits-1];
  assign side_o  = side_q[QuotBits-1];
endmodule

/* hw/rtl/segment_intersection.sv */
// ----------------------------------------------------------------------------
// segment_intersection
// Exact integer intersection test of two line segments, fully pipelined.
// ----------------------------------------------------------------------------
// One request (two segments) enters per cycle and one result leaves per cycle
// when the output side does not stall. A result passes through subtract,
// multiply, combine/classify, numerator multiply, then two bit-per-stage
// dividers for x and y (COORD_BITS+1 stages each, run side by side), then
// sign fix and add into the result register. The whole pipeline advances
// as one (global stall); a result register with a skid slot keeps the
// input side decoupled from a stalled consumer until the skid slot fills.
`include "assert_macros.svh"
module segment_intersection (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  segx_pkg::seg_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output segx_pkg::seg_rsp_t  out_rsp_o
);
  import segx_pkg::*;

  localparam int unsigned COORD_BITS = CoordBits;
  localparam int unsigned DW = COORD_BITS + 1;     // difference width
  localparam int unsigned PW = 2 * COORD_BITS + 2; // product width
  localparam int unsigned NW = PW + 1;             // d, s, t width
  localparam int unsigned MW = PW + DW;            // |t|*|delta| width
  localparam int unsigned QW = DW;                 // quotient bits, |q| <= |delta|

  // pipeline advances when the skid slot is free
  logic skid_vld_q, out_vld_q, adv;
  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // ---- stage 1: differences
  logic s1_vld_q;
  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, ox_q, oy_q;
  logic signed [COORD_BITS-1:0] ax1_q, ay1_q, bx1_q, by1_q, cx1_q, cy1_q, ex1_q, ey1_q;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, ex, ey;
  assign ax = in_req_i.first_start_x[COORD_BITS-1:0];
  assign ay = in_req_i.first_start_y[COORD_BITS-1:0];
  assign bx = in_req_i.first_end_x[COORD_BITS-1:0];
  assign by = in_req_i.first_end_y[COORD_BITS-1:0];
  assign cx = in_req_i.second_start_x[COORD_BITS-1:0];
  assign cy = in_req_i.second_start_y[COORD_BITS-1:0];
  assign ex = in_req_i.second_end_x[COORD_BITS-1:0];
  assign ey = in_req_i.second_end_y[COORD_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1x_q <= DW'(bx) - DW'(ax);
      d1y_q <= DW'(by) - DW'(ay);
      d2x_q <= DW'(ex) - DW'(cx);
      d2y_q <= DW'(ey) - DW'(cy);
      ox_q  <= DW'(ax) - DW'(cx);
      oy_q  <= DW'(ay) - DW'(cy);
      ax1_q <= ax; ay1_q <= ay; bx1_q <= bx; by1_q <= by;
      cx1_q <= cx; cy1_q <= cy; ex1_q <= ex; ey1_q <= ey;
    end
  end

  // ---- stage 2: six products
  logic s2_vld_q;
  logic signed [PW-1:0] p_d0_q, p_d1_q, p_s0_q, p_s1_q, p_t0_q, p_t1_q;
  logic signed [DW-1:0] d1x2_q, d1y2_q;
  logic signed [COORD_BITS-1:0] ax2_q, ay2_q;
  logic ovx2_q, ovy2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_d0_q <= PW'(d1x_q * d2y_q);
      p_d1_q <= PW'(d2x_q * d1y_q);
      p_s0_q <= PW'(d1x_q * oy_q);
      p_s1_q <= PW'(d1y_q * ox_q);
      p_t0_q <= PW'(d2x_q * oy_q);
      p_t1_q <= PW'(d2y_q * ox_q);
      d1x2_q <= d1x_q;
      d1y2_q <= d1y_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      // bounding-interval overlap on each axis
      ovx2_q <= ((ax1_q < bx1_q ? ax1_q : bx1_q) <= (cx1_q < ex1_q ? ex1_q : cx1_q)) &&
                ((cx1_q < ex1_q ? cx1_q : ex1_q) <= (ax1_q < bx1_q ? bx1_q : ax1_q));
      ovy2_q <= ((ay1_q < by1_q ? ay1_q : by1_q) <= (cy1_q < ey1_q ? ey1_q : cy1_q)) &&
                ((cy1_q < ey1_q ? cy1_q : ey1_q) <= (ay1_q < by1_q ? by1_q : ay1_q));
    end
  end

  // ---- stage 3: d, s, t and classification
  logic signed [NW-1:0] d_c, s_c, t_c;
  assign d_c = NW'(p_d0_q) - NW'(p_d1_q);
  assign s_c = NW'(p_s0_q) - NW'(p_s1_q);
  assign t_c = NW'(p_t0_q) - NW'(p_t1_q);
  logic [NW-1:0] dm_c, sm_c, tm_c;
  assign dm_c = d_c[NW-1] ? -d_c : d_c;
  assign sm_c = s_c[NW-1] ? -s_c : s_c;
  assign tm_c = t_c[NW-1] ? -t_c : t_c;

  logic s3_vld_q, hit3_q, col3_q;
  logic [PW-1:0] tm3_q;
  logic [NW-1:0] dm3_q;
  logic neg3x_q, neg3y_q;
  logic [DW-1:0] amx3_q, amy3_q;
  logic signed [COORD_BITS-1:0] ax3_q, ay3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (d_c == '0) begin
        col3_q <= 1'b1;
        hit3_q <= (s_c == '0) && (t_c == '0) && ovx2_q && ovy2_q;
      end else begin
        col3_q <= 1'b0;
        hit3_q <= (s_c[NW-1] == d_c[NW-1]) && (sm_c <= dm_c) &&
                  (t_c[NW-1] == d_c[NW-1]) && (tm_c <= dm_c);
      end
      // |t| < 2^(PW-1), so the top bit of the magnitude is always clear
      tm3_q   <= tm_c[PW-1:0];
      dm3_q   <= dm_c;
      neg3x_q <= (t_c[NW-1] ^ d1x2_q[DW-1] ^ d_c[NW-1]) && (t_c != '0) && (d1x2_q != '0);
      neg3y_q <= (t_c[NW-1] ^ d1y2_q[DW-1] ^ d_c[NW-1]) && (t_c != '0) && (d1y2_q != '0);
      amx3_q  <= d1x2_q[DW-1] ? -d1x2_q : d1x2_q;
      amy3_q  <= d1y2_q[DW-1] ? -d1y2_q : d1y2_q;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
    end
  end

  // ---- stage 4: numerators |t|*|delta|; on a hit the quotient is <= |delta|
  logic s4_vld_q;
  logic [MW-1:0] numx4_q, numy4_q;
  logic [NW-1:0] dm4_q;
  logic [2+2*COORD_BITS-1:0] side4_q;
  logic negx4_q, negy4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= s3_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx4_q <= MW'(tm3_q * amx3_q);
      numy4_q <= MW'(tm3_q * amy3_q);
      dm4_q   <= (hit3_q && !col3_q) ? dm3_q : NW'(1);
      side4_q <= {hit3_q, col3_q, ax3_q, ay3_q};
      negx4_q <= neg3x_q;
      negy4_q <= neg3y_q;
    end
  end

  // ---- dividers
  logic dvx_vld, dvy_vld;
  logic [QW-1:0] qx, qy;
  logic [1+2*COORD_BITS:0] sdx;
  logic [1:0] sdy;
  segx_div #(.NumBits(MW), .DenBits(NW), .QuotBits(QW), .SideBits(2+2*COORD_BITS)) u_div_x (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(s4_vld_q),
    .num_i(numx4_q), .den_i(dm4_q), .side_i(side4_q),
    .valid_o(dvx_vld), .quot_o(qx), .side_o(sdx)
  );
  segx_div #(.NumBits(MW), .DenBits(NW), .QuotBits(QW), .SideBits(2)) u_div_y (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(s4_vld_q),
    .num_i(numy4_q), .den_i(dm4_q), .side_i({negx4_q, negy4_q}),
    .valid_o(dvy_vld), .quot_o(qy), .side_o(sdy)
  );

  // ---- final stage: sign, add start, result register and skid slot
  logic hitf, colf;
  logic signed [COORD_BITS-1:0] axf, ayf, offx, offy;
  seg_rsp_t rsp_c, out_q, skid_q;
  assign hitf = sdx[1+2*COORD_BITS];
  assign colf = sdx[2*COORD_BITS];
  assign axf  = sdx[2*COORD_BITS-1:COORD_BITS];
  assign ayf  = sdx[COORD_BITS-1:0];
  // offsets wrap at the coordinate width; the sum always fits
  assign offx = sdy[1] ? -COORD_BITS'(qx) : COORD_BITS'(qx);
  assign offy = sdy[0] ? -COORD_BITS'(qy) : COORD_BITS'(qy);
  always_comb begin
    rsp_c = '0;
    if (hitf) begin
      rsp_c.hit     = 1'b1;
      rsp_c.cross_x = CoordBits'(colf ? axf : axf + offx);
      rsp_c.cross_y = CoordBits'(colf ? ayf : ayf + offy);
    end
  end

  logic take;
  assign take = out_vld_q && !out_stall_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (take) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (dvx_vld && out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else if (take || !out_vld_q) begin
        out_vld_q <= dvx_vld;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) out_q <= skid_q;
    end else if (dvx_vld && out_vld_q && !take) begin
      skid_q <= rsp_c;
    end else if (take || !out_vld_q) begin
      out_q <= rsp_c;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  `ASSERT_IMPLY(a_div_align, clk_i, rst_ni, 1'b1, dvx_vld == dvy_vld)
  `ASSERT_NEXT(a_skid_hold, clk_i, rst_ni, skid_vld_q && out_stall_i, skid_vld_q && out_vld_q)
  `ASSERT_IMPLY(a_nohit_zero, clk_i, rst_ni, out_valid_o && !out_rsp_o.hit,
                out_rsp_o.cross_x == '0 && out_rsp_o.cross_y == '0)
endmodule

/* test/segment_intersection_tb.sv */
// ----------------------------------------------------------------------------
// segment_intersection_tb
// Feeds segment pairs, directed first and then random, through the
// intersection pipeline and checks every result against an exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module segment_intersection_tb;
  import segx_pkg::*;

  localparam int Cb = CoordBits;
  localparam int PipeDepth = Cb + 6;
  localparam int NumRandom = 1730;
  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  seg_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  seg_rsp_t out_rsp_o;

  segment_intersection DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  seg_rsp_t pending_rsp[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;  // long stretch with no idling on either side

  // Exact intersection point, with long math wide enough for products.
  function automatic seg_rsp_t predict_cross(seg_req_t r);
    longint ax, ay, bx, by, cx, cy, ex, ey;
    longint d1x, d1y, d2x, d2y, ox, oy, dn, sn, tn;
    longint lox1, hix1, lox2, hix2, loy1, hiy1, loy2, hiy2;
    seg_rsp_t p;
    ax = r.first_start_x;  ay = r.first_start_y;
    bx = r.first_end_x;    by = r.first_end_y;
    cx = r.second_start_x; cy = r.second_start_y;
    ex = r.second_end_x;   ey = r.second_end_y;
    d1x = bx - ax; d1y = by - ay;
    d2x = ex - cx; d2y = ey - cy;
    ox = ax - cx;  oy = ay - cy;
    dn = d1x * d2y - d2x * d1y;
    sn = d1x * oy - d1y * ox;
    tn = d2x * oy - d2y * ox;
    p = '0;
    if (dn == 0) begin
      lox1 = ax < bx ? ax : bx; hix1 = ax < bx ? bx : ax;
      lox2 = cx < ex ? cx : ex; hix2 = cx < ex ? ex : cx;
      loy1 = ay < by ? ay : by; hiy1 = ay < by ? by : ay;
      loy2 = cy < ey ? cy : ey; hiy2 = cy < ey ? ey : cy;
      // collinear and touching: report the first segment's start
      if (sn == 0 && tn == 0 && lox1 <= hix2 && lox2 <= hix1 &&
          loy1 <= hiy2 && loy2 <= hiy1) begin
        p.hit = 1'b1;
        p.cross_x = r.first_start_x;
        p.cross_y = r.first_start_y;
      end
    end else if ((sn >= 0) == (dn >= 0) && (tn >= 0) == (dn >= 0) &&
                 (sn < 0 ? -sn : sn) <= (dn < 0 ? -dn : dn) &&
                 (tn < 0 ? -tn : tn) <= (dn < 0 ? -dn : dn)) begin
      // |t*delta| < 2^51, fits; SV division truncates toward zero
      p.hit = 1'b1;
      p.cross_x = Cb'(ax + (tn * d1x) / dn);
      p.cross_y = Cb'(ay + (tn * d1y) / dn);
    end
    return p;
  endfunction

  function automatic logic [Cb-1:0] rand_coord(int mode);
    case (mode)
      0: return Cb'($urandom);
      1: return Cb'($urandom_range(0, 31)) - Cb'(16);
      default: return $urandom_range(0, 1) ? {1'b1, {(Cb-1){1'b0}}} : {1'b0, {(Cb-1){1'b1}}};
    endcase
  endfunction

  // Random segment pair: mostly crossing or near-degenerate shapes.
  function automatic seg_req_t rand_pair();
    seg_req_t r;
    int kind, md;
    logic signed [Cb-1:0] c0, c1, k;
    kind = $urandom_range(0, 9);
    md = $urandom_range(0, 9) == 0 ? 2 : ($urandom_range(0, 2) == 0 ? 1 : 0);
    r = {rand_coord(md), rand_coord(md), rand_coord(md), rand_coord(md),
         rand_coord(md), rand_coord(md), rand_coord(md), rand_coord(md)};
    if (kind < 4) begin
      // second segment through a point on the first: likely hit
      c0 = r.first_start_x + (r.first_end_x - r.first_start_x) / 2;
      c1 = r.first_start_y + (r.first_end_y - r.first_start_y) / 2;
      k = Cb'($urandom_range(0, 2000)) - Cb'(1000);
      r.second_start_x = c0 - k; r.second_end_x = c0 + k;
      k = Cb'($urandom_range(0, 2000)) - Cb'(1000);
      r.second_start_y = c1 - k; r.second_end_y = c1 + k;
    end else if (kind < 6) begin
      // collinear: second segment along the first's direction
      c0 = r.first_end_x - r.first_start_x;
      c1 = r.first_end_y - r.first_start_y;
      r.first_end_x = r.first_start_x + (c0 >>> 4);
      r.first_end_y = r.first_start_y + (c1 >>> 4);
      k = Cb'($urandom_range(0, 4)) - Cb'(2);
      r.second_start_x = r.first_start_x + k * (c0 >>> 4);
      r.second_start_y = r.first_start_y + k * (c1 >>> 4);
      r.second_end_x = r.second_start_x + (c0 >>> 4);
      r.second_end_y = r.second_start_y + (c1 >>> 4);
    end else if (kind == 6) begin
      // parallel offset
      r.second_end_x = r.second_start_x + (r.first_end_x - r.first_start_x);
      r.second_end_y = r.second_start_y + (r.first_end_y - r.first_start_y);
    end
    return r;
  endfunction

  typedef struct {
    seg_req_t req;
    bit       known;
    seg_rsp_t rsp;
  } cross_row_t;

  localparam logic [Cb-1:0] Pmax = {1'b0, {(Cb-1){1'b1}}};
  localparam logic [Cb-1:0] Nmin = {1'b1, {(Cb-1){1'b0}}};

  cross_row_t directed_rows[] = '{
    '{'0, 1, '{1'b1, 16'sd0, 16'sd0}},                               // all points at origin
    '{{16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd10, 16'sd10, 16'sd0},
      1, '{1'b1, 16'sd5, 16'sd5}},                                    // X crossing
    '{{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd5, 16'sd10, 16'sd5},
      1, '{1'b0, 16'sd0, 16'sd0}},                                    // parallel
    '{{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd5, 16'sd0, 16'sd20, 16'sd0},
      1, '{1'b1, 16'sd0, 16'sd0}},                                    // collinear overlap
    '{{16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd5, 16'sd0, 16'sd20, 16'sd0},
      1, '{1'b0, 16'sd0, 16'sd0}},                                    // collinear apart
    '{{16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3},
      1, '{1'b1, 16'sd3, 16'sd3}},                                    // coincident points
    '{{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd10, 16'sd0, 16'sd10, 16'sd9},
      1, '{1'b1, 16'sd10, 16'sd0}},                                   // touch at endpoint
    '{{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd11, -16'sd5, 16'sd11, 16'sd5},
      1, '{1'b0, 16'sd0, 16'sd0}},                                    // just misses
    '{{Nmin, Nmin, Pmax, Pmax, Nmin, Pmax, Pmax, Nmin}, 0, '0},      // extreme X
    '{{Pmax, Pmax, Nmin, Nmin, Pmax, Nmin, Nmin, Pmax}, 0, '0},
    '{{Nmin, Nmin, Nmin, Nmin, Pmax, Pmax, Pmax, Pmax}, 0, '0},      // far points
    '{{Nmin, Pmax, Pmax, Nmin, Nmin, Nmin, Pmax, Pmax}, 0, '0},
    '{{16'sd0, 16'sd0, 16'sd7, 16'sd3, 16'sd0, 16'sd3, 16'sd7, -16'sd2}, 0, '0},
    '{{-16'sd1, -16'sd1, 16'sd9, -16'sd7, 16'sd2, -16'sd9, 16'sd2, 16'sd9}, 0, '0},
    '{{Nmin, 16'sd0, Pmax, 16'sd1, 16'sd0, Nmin, 16'sd1, Pmax}, 0, '0}
  };

  // Request side: drive at the rising edge, hold while stalled.
  task automatic send_req(seg_req_t r);
    while (!quiet_phase && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Expectation pushed when the request is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) pending_rsp.push_back(predict_cross(in_req_i));
  end

  // Result side: random stall, compare on accept.
  always @(posedge clk_i) begin
    seg_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_rsp_o);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp_o.hit !== want.hit || out_rsp_o.cross_x !== want.cross_x ||
            out_rsp_o.cross_y !== want.cross_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                     want.hit, want.cross_x, want.cross_y,
                     out_rsp_o.hit, out_rsp_o.cross_x, out_rsp_o.cross_y);
        end
      end
    end
    out_stall_i <= !quiet_phase && ($urandom_range(0, 99) < 16);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    seg_req_t r;
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed table; known rows are checked against the typed answer too
    foreach (directed_rows[i]) begin
      r = directed_rows[i].req;
      if (directed_rows[i].known && predict_cross(r) !== directed_rows[i].rsp) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
      end
      send_req(r);
    end
    for (n = 0; n < NumRandom; n++) begin
      quiet_phase <= (n >= 600 && n < 900);
      send_req(rand_pair());
    end
    in_valid_i <= 1'b0;
    quiet_phase <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/segx_pkg.sv
hw/rtl/segx_div.sv
hw/rtl/segment_intersection.sv
test/segment_intersection_tb.sv
